FILE: rtl/core/tpad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpad_pkg
// Shared types and constants for the four-phase ToF demodulator.
// ----------------------------------------------------------------------------
package tpad_pkg;

    localparam int CordicSteps = 16;
    localparam int SqrtSteps   = 13;

    localparam int CFG_MODE   = 0;
    localparam int CFG_OFFSET = 1;
    localparam int CFG_THRESH = 2;

    localparam logic [1:0] SEL_RAW   = 2'd0;
    localparam logic [1:0] SEL_AMP   = 2'd1;
    localparam logic [1:0] SEL_PHASE = 2'd2;
    localparam logic [1:0] SEL_ZERO  = 2'd3;

    localparam logic signed [19:0] ZQuarterTurn = 20'sd102944;
    localparam logic signed [16:0] AngPi        = 17'sd25736;
    localparam logic signed [16:0] AngPiTrunc   = 17'sd25735;
    localparam logic signed [15:0] AngHalfPi    = 16'sd12868;
    localparam logic [15:0]        PhScaleNum   = 16'd32767;
    localparam logic [15:0]        PhScaleDen   = 16'd51471;
    localparam logic [31:0]        PhRecip      =
        32'((64'(PhScaleNum) << 32) / 64'(PhScaleDen));
    localparam logic [15:0]        PhMask       = 16'hFFFF;

    typedef struct packed {
        logic signed [12:0] ipw;
        logic [15:0]        raw;
        logic               fs;
        logic               spec;
        logic signed [15:0] spec_ang;
    } t_pay;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [19:0] z;
        logic [25:0]        n;
        logic [26:0]        root;
        t_pay               pay;
    } t_cell_data;

    typedef struct packed {
        logic [15:0] sc;
        logic [12:0] amp;
        t_pay        pay;
    } t_tail_out;

    function automatic logic [19:0] atan_step(input int k);
        logic [19:0] v;
        begin
            case (k)
                0:  v = 20'd51472;
                1:  v = 20'd30386;
                2:  v = 20'd16055;
                3:  v = 20'd8150;
                4:  v = 20'd4091;
                5:  v = 20'd2047;
                6:  v = 20'd1024;
                7:  v = 20'd512;
                8:  v = 20'd256;
                9:  v = 20'd128;
                10: v = 20'd64;
                11: v = 20'd32;
                12: v = 20'd16;
                13: v = 20'd8;
                14: v = 20'd4;
                15: v = 20'd2;
                default: v = 20'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tpad_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpad interfaces
// Pixel, result and configuration channels, valid/ready.
// ----------------------------------------------------------------------------
interface tpad_pix_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] sample0;
    logic signed [11:0] sample1;
    logic signed [11:0] sample2;
    logic signed [11:0] sample3;
    logic               frame_start;
    modport source (output valid, sample0, sample1, sample2, sample3, frame_start,
                    input ready);
    modport sink   (input valid, sample0, sample1, sample2, sample3, frame_start,
                    output ready);
endinterface

interface tpad_res_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] in_phase_word;
    logic [15:0]        result_word;
    logic [15:0]        running_max;
    modport source (output valid, in_phase_word, result_word, running_max,
                    input ready);
    modport sink   (input valid, in_phase_word, result_word, running_max,
                    output ready);
endinterface

interface tpad_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tpad_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpad_cell
// One CORDIC vectoring step per cell, plus one square-root digit step in cells 0 to 12.
// ----------------------------------------------------------------------------
module tpad_cell #(
    parameter int K = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  tpad_pkg::t_cell_data i_d,
    output logic                 o_valid,
    output tpad_pkg::t_cell_data o_d
);
    logic                 r_valid;
    tpad_pkg::t_cell_data r_d;
    tpad_pkg::t_cell_data n_d;
    logic signed [31:0]   a_sh;
    logic signed [31:0]   b_sh;
    logic [26:0]          trial;

    always_comb begin
        n_d   = i_d;
        a_sh  = i_d.x >>> K;
        b_sh  = i_d.y >>> K;
        trial = 27'd0;
        if (i_d.y >= 0) begin
            n_d.x = i_d.x + b_sh;
            n_d.y = i_d.y - a_sh;
            n_d.z = i_d.z + $signed(tpad_pkg::atan_step(K));
        end else begin
            n_d.x = i_d.x - b_sh;
            n_d.y = i_d.y + a_sh;
            n_d.z = i_d.z - $signed(tpad_pkg::atan_step(K));
        end
        if (K < tpad_pkg::SqrtSteps) begin
            trial = i_d.root + (27'd1 << (2 * (tpad_pkg::SqrtSteps - 1 - K)));
            if ({1'b0, i_d.n} >= trial) begin
                n_d.n    = 26'({1'b0, i_d.n} - trial);
                n_d.root = (i_d.root >> 1) + (27'd1 << (2 * (tpad_pkg::SqrtSteps - 1 - K)));
            end else begin
                n_d.root = i_d.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule
`default_nettype wire

FILE: rtl/core/tpad_tail.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpad_tail
// Angle rounding and clamp, then phase scaling by reciprocal with correction.
// ----------------------------------------------------------------------------
module tpad_tail (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  tpad_pkg::t_cell_data i_d,
    output logic                 o_valid,
    output tpad_pkg::t_tail_out  o_d
);
    logic               r_v1;
    logic [15:0]        r_p;
    logic [47:0]        r_pm;
    logic [12:0]        r_amp1;
    tpad_pkg::t_pay     r_pay1;
    logic               r_v2;
    tpad_pkg::t_tail_out r_out;

    logic signed [19:0] zr;
    logic signed [16:0] ang;
    logic [15:0]        n_p;
    logic [15:0]        q0;
    logic [31:0]        rem;
    logic [15:0]        n_sc;

    always_comb begin
        zr  = i_d.z + 20'sd4;
        ang = 17'(zr >>> 3);
        if (ang > tpad_pkg::AngPi) ang = tpad_pkg::AngPi;
        if (ang < -tpad_pkg::AngPi) ang = -tpad_pkg::AngPi;
        if (i_d.pay.spec) ang = 17'(i_d.pay.spec_ang);
        n_p = 16'(ang + tpad_pkg::AngPiTrunc);
    end

    always_comb begin
        q0   = r_pm[47:32];
        rem  = ({16'd0, r_p} << 15) - {16'd0, r_p} - ({16'd0, q0} * {16'd0, tpad_pkg::PhScaleDen});
        n_sc = (rem >= {16'd0, tpad_pkg::PhScaleDen}) ? q0 + 16'd1 : q0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_p        <= n_p;
            r_pm       <= {32'd0, n_p} * {16'd0, tpad_pkg::PhRecip};
            r_amp1     <= i_d.root[12:0];
            r_pay1     <= i_d.pay;
            r_out.sc   <= n_sc;
            r_out.amp  <= r_amp1;
            r_out.pay  <= r_pay1;
        end
    end

    assign o_valid = r_v2;
    assign o_d     = r_out;
endmodule
`default_nettype wire

FILE: rtl/core/tof_phase_amplitude_demod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tof_phase_amplitude_demod
// Four-phase ToF demodulation: amplitude, phase, running frame maximum.
// Path: input register, pre-rotation register, CORDIC/root cells, tail registers, output register.
// Throughput: one pixel per cycle while the output is not held, set by the 16-cell CORDIC/root chain.
// The whole chain holds when the output register is full and not taken.
// Reset (synchronous, active low) clears config registers, valid bits, frame max.
// ----------------------------------------------------------------------------
module tof_phase_amplitude_demod (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tpad_pix_if.sink      i_pix,
    tpad_cfg_if.sink      i_cfg,
    tpad_res_if.source    o_res
);
    localparam int N = tpad_pkg::CordicSteps;

    logic [1:0]  r_mode;
    logic [15:0] r_offset;
    logic [15:0] r_thresh;

    logic               en;
    logic               r_a_valid;
    logic signed [11:0] r_s0, r_s1, r_s2, r_s3;
    logic               r_fs;

    logic                 r_c0_valid;
    tpad_pkg::t_cell_data r_c0;
    tpad_pkg::t_cell_data n_c0;
    logic signed [12:0]   iv, qv;
    logic signed [31:0]   ix, qx;

    tpad_pkg::t_cell_data w_d [0:N];
    logic                 w_v [0:N];

    logic                 tail_v;
    tpad_pkg::t_tail_out  tail_d;

    logic               r_out_valid;
    logic signed [12:0] r_ipw;
    logic [15:0]        r_res;
    logic [15:0]        r_max;
    logic               r_out_fs;
    logic [15:0]        n_res;
    logic [15:0]        n_max;
    logic [15:0]        sh;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tpad_pkg::SEL_RAW;
            r_offset <= 16'd0;
            r_thresh <= 16'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                2'(tpad_pkg::CFG_MODE):   r_mode   <= i_cfg.data[1:0];
                2'(tpad_pkg::CFG_OFFSET): r_offset <= i_cfg.data;
                2'(tpad_pkg::CFG_THRESH): r_thresh <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign en          = !r_out_valid || o_res.ready;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_pix.valid;
        end
        if (en) begin
            r_s0 <= i_pix.sample0;
            r_s1 <= i_pix.sample1;
            r_s2 <= i_pix.sample2;
            r_s3 <= i_pix.sample3;
            r_fs <= i_pix.frame_start;
        end
    end

    always_comb begin
        iv = 13'(r_s2) - 13'(r_s0);
        qv = 13'(r_s3) - 13'(r_s1);
        ix = {{3{iv[12]}}, iv, 16'd0};
        qx = {{3{qv[12]}}, qv, 16'd0};
        n_c0      = '0;
        n_c0.n    = 26'(iv * iv) + 26'(qv * qv);
        n_c0.root = 27'd0;
        if (iv < 0) begin
            if (qv >= 0) begin
                n_c0.x = qx;
                n_c0.y = -ix;
                n_c0.z = tpad_pkg::ZQuarterTurn;
            end else begin
                n_c0.x = -qx;
                n_c0.y = ix;
                n_c0.z = -tpad_pkg::ZQuarterTurn;
            end
        end else begin
            n_c0.x = ix;
            n_c0.y = qx;
            n_c0.z = 20'sd0;
        end
        n_c0.pay.fs = r_fs;
        if (r_mode == tpad_pkg::SEL_RAW) begin
            n_c0.pay.ipw = 13'(r_s2);
        end else begin
            n_c0.pay.ipw = iv;
        end
        n_c0.pay.raw = 16'(r_s3);
        if (qv == 0) begin
            n_c0.pay.spec     = 1'b1;
            n_c0.pay.spec_ang = (iv < 0) ? 16'(tpad_pkg::AngPi) : 16'sd0;
        end else if (iv == 0) begin
            n_c0.pay.spec     = 1'b1;
            n_c0.pay.spec_ang = (qv > 0) ? tpad_pkg::AngHalfPi : -tpad_pkg::AngHalfPi;
        end else begin
            n_c0.pay.spec     = 1'b0;
            n_c0.pay.spec_ang = 16'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_valid <= 1'b0;
        end else if (en) begin
            r_c0_valid <= r_a_valid;
        end
        if (en) begin
            r_c0 <= n_c0;
        end
    end

    assign w_d[0] = r_c0;
    assign w_v[0] = r_c0_valid;

    for (genvar k = 0; k < N; k++) begin : g_cell
        tpad_cell #(.K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_v[k]),
            .i_d     (w_d[k]),
            .o_valid (w_v[k+1]),
            .o_d     (w_d[k+1])
        );
    end

    tpad_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_v[N]),
        .i_d     (w_d[N]),
        .o_valid (tail_v),
        .o_d     (tail_d)
    );

    always_comb begin
        sh = {1'b0, 15'(tail_d.sc + r_offset)};
        case (r_mode)
            tpad_pkg::SEL_RAW:   n_res = tail_d.pay.raw;
            tpad_pkg::SEL_AMP:   n_res = {3'd0, tail_d.amp};
            tpad_pkg::SEL_PHASE: n_res = ({3'd0, tail_d.amp} < r_thresh) ? tpad_pkg::PhMask : sh;
            default:             n_res = 16'd0;
        endcase
        n_max = tail_d.pay.fs ? 16'd0 : r_max;
        if (n_res > n_max) n_max = n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_max       <= 16'd0;
        end else if (en) begin
            r_out_valid <= tail_v;
            if (tail_v) begin
                r_max <= n_max;
            end
        end
        if (en) begin
            r_ipw    <= tail_d.pay.ipw;
            r_res    <= n_res;
            r_out_fs <= tail_d.pay.fs;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.in_phase_word = r_ipw;
    assign o_res.result_word   = r_res;
    assign o_res.running_max   = r_max;

`ifndef SYNTHESIS
    a_max_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_max >= r_res))
        else $error("running max below result word");
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fs) |-> (r_max == r_res))
        else $error("frame start did not restart maximum");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_valid)
        else $error("output valid after reset");
    a_zero_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_mode == tpad_pkg::SEL_ZERO) |-> (r_res == 16'd0))
        else $error("zero mode gave non-zero word");
`endif
endmodule
`default_nettype wire

FILE: dv/tof_phase_amplitude_demod_tb.sv
// ----------------------------------------------------------------------------
// tof_phase_amplitude_demod_tb
// Drives pixel words with random gaps and result back-pressure, predicts I,
// the raw, amplitude, phase or zero word and frame maximum per pixel, and
// compares every result word field by field. Register settings change between idle phases.
// ----------------------------------------------------------------------------
module tof_phase_amplitude_demod_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [11:0] s0, s1, s2, s3;
        logic               fs;
    } t_pix;

    typedef struct packed {
        logic signed [12:0] ipw;
        logic [15:0]        res;
        logic [15:0]        rmax;
    } t_demod;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tpad_pix_if pix();
    tpad_cfg_if cfg();
    tpad_res_if res();

    tof_phase_amplitude_demod DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix), .i_cfg(cfg), .o_res(res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pix   pending_pix[$];
    t_pix   sent_pix[$];
    t_demod expected_words[$];
    logic [1:0]  cur_mode = tpad_pkg::SEL_RAW;
    logic [15:0] cur_offset = '0;
    logic [15:0] cur_thresh = '0;
    logic [15:0] frame_peak = '0;
    int  errors = 0;
    int  idle_pct = 30;
    int  hold_cycles = 0;
    int  stall_count = 0;
    int  watchdog = 0;

    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] r;
        r = 0;
        while ((r + 1) * (r + 1) <= n) r = r + 1;
        return r;
    endfunction

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vector_angle(longint iv, longint qv);
        longint x, y, z, a, b, r;
        longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (qv == 0) return (iv < 0) ? 25736 : 0;
        if (iv == 0) return (qv > 0) ? 12868 : -12868;
        if (iv < 0) begin
            if (qv >= 0) begin
                x = qv; y = -iv; z = 102944;
            end else begin
                x = -qv; y = iv; z = -102944;
            end
        end else begin
            x = iv; y = qv;
        end
        x = x * 65536;
        y = y * 65536;
        for (int k = 0; k < 16; k++) begin
            a = asr(x, k);
            b = asr(y, k);
            if (y >= 0) begin
                x += b; y -= a; z += tab[k];
            end else begin
                x -= b; y += a; z -= tab[k];
            end
        end
        r = asr(z + 4, 3);
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        return r;
    endfunction

    function automatic t_demod demodulate(t_pix p);
        t_demod d;
        longint iv, qv, amp, sc;
        logic [15:0] ph, word;
        iv = longint'(p.s2) - longint'(p.s0);
        qv = longint'(p.s3) - longint'(p.s1);
        word = '0;
        if (p.fs) frame_peak = '0;
        if (cur_mode == tpad_pkg::SEL_RAW) begin
            d.ipw = 13'(longint'(p.s2));
            word = 16'(longint'(p.s3));
        end else begin
            d.ipw = 13'(iv);
            amp = longint'(floor_root(64'(iv * iv + qv * qv)));
            if (cur_mode == tpad_pkg::SEL_AMP) begin
                word = 16'(amp);
            end else if (cur_mode == tpad_pkg::SEL_PHASE) begin
                ph = 16'(vector_angle(iv, qv) + 25735);
                sc = (longint'(ph) * 32767) / 51471;
                word = (amp < longint'(cur_thresh)) ? 16'hFFFF
                                                    : {1'b0, 15'(sc + cur_offset)};
            end
        end
        if (word > frame_peak) frame_peak = word;
        d.res = word;
        d.rmax = frame_peak;
        return d;
    endfunction

    // pixel driver
    logic pix_taken = 1'b0;
    always @(posedge i_clk) pix_taken <= pix.valid && pix.ready;

    always @(negedge i_clk) begin
        if (i_rst_n && (!pix.valid || pix_taken)) begin
            if (pending_pix.size() != 0 && $urandom_range(99) >= idle_pct) begin
                {pix.sample0, pix.sample1, pix.sample2, pix.sample3, pix.frame_start}
                    <= pending_pix.pop_front();
                pix.valid <= 1'b1;
            end else begin
                pix.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready) begin
            expected_words.push_back(demodulate({pix.sample0, pix.sample1,
                pix.sample2, pix.sample3, pix.frame_start}));
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_demod e;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (res.in_phase_word !== e.ipw) begin
                    $error("in_phase_word exp %0d got %0d", e.ipw, res.in_phase_word);
                    errors++;
                end
                if (res.result_word !== e.res) begin
                    $error("result_word exp %0h got %0h", e.res, res.result_word);
                    errors++;
                end
                if (res.running_max !== e.rmax) begin
                    $error("running_max exp %0h got %0h", e.rmax, res.running_max);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready) || !i_rst_n) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog > 5000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg.index <= idx;
        cfg.data  <= val;
        cfg.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        case (idx)
            2'(tpad_pkg::CFG_MODE):   cur_mode = val[1:0];
            2'(tpad_pkg::CFG_OFFSET): cur_offset = val;
            default:                  cur_thresh = val;
        endcase
    endtask

    task automatic drain();
        while (pending_pix.size() != 0 || pix.valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic signed [11:0] rnd_sample();
        case ($urandom_range(5))
            0: return 12'sh800;
            1: return 12'sh7FF;
            2: return 12'sh000;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic t_pix rnd_pix();
        t_pix p;
        p.s0 = rnd_sample(); p.s1 = rnd_sample();
        p.s2 = rnd_sample(); p.s3 = rnd_sample();
        p.fs = ($urandom_range(19) == 0);
        if ($urandom_range(9) == 0) p.s1 = p.s3;
        if ($urandom_range(9) == 0) p.s0 = p.s2;
        return p;
    endfunction

    initial begin
        logic [15:0] offs[4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1234};
        logic [15:0] ths[4]  = '{16'hFFFF, 16'h0000, 16'd700, 16'd3000};
        pix.valid = 1'b0;
        pix.sample0 = '0; pix.sample1 = '0; pix.sample2 = '0; pix.sample3 = '0;
        pix.frame_start = 1'b0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        res.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(2'(tpad_pkg::CFG_MODE), 16'(ph % 4));
            write_reg(2'(tpad_pkg::CFG_OFFSET), offs[ph % 4]);
            write_reg(2'(tpad_pkg::CFG_THRESH), ths[(ph / 2) % 4]);
            if (ph == 0 || ph == 2) begin
                // axes, corners, angle wrap near -1
                pending_pix.push_back({12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1});
                pending_pix.push_back({12'sh800, 12'sh800, 12'sh7FF, 12'sh7FF, 1'b0});
                pending_pix.push_back({12'sh7FF, 12'sh7FF, 12'sh800, 12'sh800, 1'b0});
                pending_pix.push_back({12'sd0, 12'sd0, 12'sd5, 12'sd0, 1'b0});
                pending_pix.push_back({12'sd5, 12'sd0, 12'sd0, 12'sd0, 1'b0});
                pending_pix.push_back({12'sd0, 12'sd0, 12'sd0, 12'sd9, 1'b0});
                pending_pix.push_back({12'sd0, 12'sd9, 12'sd0, 12'sd0, 1'b0});
                pending_pix.push_back({12'sd0, 12'sd0, -12'sd2000, -12'sd1, 1'b0});
                pending_pix.push_back({12'sd0, 12'sd1, -12'sd2000, 12'sd0, 1'b1});
            end
            for (int n = 0; n < 62; n++) pending_pix.push_back(rnd_pix());
            idle_pct = (ph == 3) ? 0 : 30;
            if (ph == 5) hold_cycles = 200;
            drain();
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/tpad_pkg.sv
rtl/core/tpad_if.sv
rtl/core/tpad_cell.sv
rtl/core/tpad_tail.sv
rtl/core/tof_phase_amplitude_demod.sv
dv/tof_phase_amplitude_demod_tb.sv
